### design/cdbe_pkg.sv
// ----------------------------------------------------------------------------
// cdbe_pkg
// Shared types and constants for the counter delta byte encoder.
// ----------------------------------------------------------------------------
package cdbe_pkg;

  localparam logic [7:0] CODE_ZERO  = 8'h00;
  localparam logic [7:0] CODE_INT8  = 8'h01;
  localparam logic [7:0] CODE_INT16 = 8'h02;
  localparam logic [7:0] CODE_RAW   = 8'h03;

  localparam logic [62:0] MAG_127   = 63'h405F_C000_0000_0000;
  localparam logic [62:0] MAG_32767 = 63'h40DF_FFC0_0000_0000;

  localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
  localparam logic [10:0] EXP_MAX     = 11'h7FF;
  localparam logic [10:0] EXP_BIAS    = 11'd1023;
  localparam logic [10:0] EXP_INT_TOP = 11'd1075;

  localparam int unsigned NUM_STAGES = 7;

  typedef logic [63:0] word_t;
  typedef logic [3:0]  cnt_t;

  // leading zero count of a 56-bit word, 56 when zero
  function automatic logic [5:0] lzc56(input logic [55:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd56;
    found = 1'b0;
    for (int i = 55; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 6'(55 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

### design/counter_delta_byte_encoder.sv
// ----------------------------------------------------------------------------
// counter_delta_byte_encoder
// Double-precision delta encoder emitting a byte stream.
// ----------------------------------------------------------------------------
// Each item is a raw 64-bit double. A series start goes out as its 8 bytes,
// low byte first. Otherwise the block forms sample - previous (round to
// nearest even, full IEEE handling) through a seven-stage pipeline and
// sends 0x00; 0x01 + int8; 0x02 + int16; or 0x03 + 8 delta bytes. Results
// leave one byte per cycle unless out_stall holds them, so an item takes 1
// to 9 bytes of output and that byte serializer sets the sustained rate;
// the next item is accepted and computed while the current bytes drain.
// Its first byte leaves once it has passed the pipeline into the buffer.
module counter_delta_byte_encoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cdbe_pkg::word_t      in_sample_bits,
  input  logic                 in_series_start,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 out_last_byte
);
  import cdbe_pkg::*;

  logic [NUM_STAGES-1:0] pipe_v_r;
  logic                  adv;
  logic                  load_ok;
  logic                  in_take;
  logic                  out_take;

  word_t prev_r;
  // stage 0
  word_t a0_r, b0_r;
  logic  st0_r;
  // stage 1
  logic        st1_r, alt_sel1_r, sign1_r, sub1_r;
  word_t       alt1_r;
  logic [10:0] ebig1_r;
  logic [52:0] mbig1_r, msml1_r;
  logic [5:0]  dist1_r;
  // stage 2
  logic        st2_r, alt_sel2_r, sign2_r, sub2_r;
  word_t       alt2_r;
  logic [10:0] ebig2_r;
  logic [55:0] big2_r, sml2_r;
  // stage 3
  logic        st3_r, alt_sel3_r, sign3_r;
  word_t       alt3_r;
  logic [10:0] ebig3_r;
  logic [56:0] sum3_r;
  // stage 4
  logic        st4_r, alt_sel4_r, sign4_r, zero4_r;
  word_t       alt4_r;
  logic [11:0] e4_r;
  logic [55:0] m4_r;
  logic [5:0]  sh4_r;
  // stage 5
  logic        st5_r, alt_sel5_r, sign5_r, zero5_r;
  word_t       alt5_r;
  logic [11:0] e5_r;
  logic [55:0] m5_r;
  // stage 6
  logic        st6_r, alt_sel6_r, zero6_r;
  word_t       alt6_r, d6_r;
  // serializer
  logic [71:0] buf_r;
  cnt_t        cnt_r;

  assign load_ok  = (cnt_r == '0) || ((cnt_r == 4'd1) && !out_stall);
  assign adv      = !pipe_v_r[NUM_STAGES-1] || load_ok;
  assign in_stall = !adv;
  assign in_take  = in_valid && !in_stall;
  assign out_valid     = (cnt_r != '0);
  assign out_byte      = buf_r[7:0];
  assign out_last_byte = (cnt_r == 4'd1);
  assign out_take      = out_valid && !out_stall;

  // stage 1: unpack, specials, operand swap
  logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_big;
  logic [10:0] ea, eb, ea_e, eb_e, d_raw;
  logic [52:0] ma, mb;
  word_t       alt_c;
  logic        alt_sel_c;
  always_comb begin
    sa    = a0_r[63];
    sb    = ~b0_r[63];
    ea    = a0_r[62:52];
    eb    = b0_r[62:52];
    ea_e  = (ea == '0) ? 11'd1 : ea;
    eb_e  = (eb == '0) ? 11'd1 : eb;
    ma    = {ea != '0, a0_r[51:0]};
    mb    = {eb != '0, b0_r[51:0]};
    a_nan = (ea == EXP_MAX) && (a0_r[51:0] != '0);
    b_nan = (eb == EXP_MAX) && (b0_r[51:0] != '0);
    a_inf = (ea == EXP_MAX) && (a0_r[51:0] == '0);
    b_inf = (eb == EXP_MAX) && (b0_r[51:0] == '0);
    a_big = a0_r[62:0] >= b0_r[62:0];
    d_raw = a_big ? (ea_e - eb_e) : (eb_e - ea_e);
    alt_sel_c = 1'b1;
    priority if (st0_r)                    alt_c = a0_r;
    else if (a_nan)                        alt_c = a0_r | (64'd1 << 51);
    else if (b_nan)                        alt_c = b0_r | (64'd1 << 51);
    else if (a_inf && b_inf && (sa != sb)) alt_c = DEFAULT_NAN;
    else if (a_inf)                        alt_c = {sa, EXP_MAX, 52'd0};
    else if (b_inf)                        alt_c = {sb, EXP_MAX, 52'd0};
    else begin
      alt_c     = '0;
      alt_sel_c = 1'b0;
    end
  end

  // stage 2: align with sticky
  logic [119:0] wide_c;
  always_comb wide_c = {msml1_r, 3'b000, 64'd0} >> dist1_r;

  // stage 4: carry or leading zero count
  logic [5:0]  lz_c;
  logic [10:0] lim_c;
  always_comb begin
    lz_c  = lzc56(sum3_r[55:0]);
    lim_c = ebig3_r - 11'd1;
  end

  // stage 6: round to nearest even, pack
  logic        inc_c;
  logic [53:0] r_c;
  logic [11:0] ef_c;
  word_t       d_c;
  always_comb begin
    inc_c = m5_r[2] & (m5_r[1] | m5_r[0] | m5_r[3]);
    r_c   = {1'b0, m5_r[55:3]} + 54'(inc_c);
    priority if (r_c[53]) ef_c = e5_r + 12'd1;
    else if (r_c[52])     ef_c = e5_r;
    else                  ef_c = '0;
    if (ef_c >= {1'b0, EXP_MAX}) d_c = {sign5_r, EXP_MAX, 52'd0};
    else d_c = {sign5_r, ef_c[10:0], r_c[53] ? r_c[52:1] : r_c[51:0]};
  end

  // stage 7: classify and build bytes
  word_t       dbits;
  logic        le127, le32767;
  logic [5:0]  ish;
  logic [52:0] imag;
  logic [15:0] ival;
  logic [71:0] bytes_c;
  cnt_t        n_c;
  always_comb begin
    dbits   = alt_sel6_r ? alt6_r : d6_r;
    le127   = dbits[62:0] <= MAG_127;
    le32767 = dbits[62:0] <= MAG_32767;
    ish     = 6'(EXP_INT_TOP - dbits[62:52]);
    imag    = (dbits[62:52] < EXP_BIAS) ? '0 : ({1'b1, dbits[51:0]} >> ish);
    ival    = dbits[63] ? (16'd0 - imag[15:0]) : imag[15:0];
    bytes_c = '0;
    priority if (st6_r) begin
      bytes_c = {8'd0, alt6_r};
      n_c     = 4'd8;
    end else if (!alt_sel6_r && zero6_r) begin
      bytes_c = {64'd0, CODE_ZERO};
      n_c     = 4'd1;
    end else if (le127) begin
      bytes_c = {56'd0, ival[7:0], CODE_INT8};
      n_c     = 4'd2;
    end else if (le32767) begin
      bytes_c = {48'd0, ival, CODE_INT16};
      n_c     = 4'd3;
    end else begin
      bytes_c = {dbits, CODE_RAW};
      n_c     = 4'd9;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_v_r <= '0;
      prev_r   <= '0;
      cnt_r    <= '0;
    end else begin
      if (adv) pipe_v_r <= {pipe_v_r[NUM_STAGES-2:0], in_take};
      if (in_take) prev_r <= in_sample_bits;
      if (load_ok && pipe_v_r[NUM_STAGES-1]) cnt_r <= n_c;
      else if (out_take) cnt_r <= cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && pipe_v_r[NUM_STAGES-1]) begin
      buf_r <= bytes_c;
    end else if (out_take) begin
      buf_r <= {8'd0, buf_r[71:8]};
    end
    if (adv) begin
      a0_r  <= in_sample_bits;
      b0_r  <= prev_r;
      st0_r <= in_series_start;

      st1_r      <= st0_r;
      alt_sel1_r <= alt_sel_c;
      alt1_r     <= alt_c;
      sign1_r    <= a_big ? sa : sb;
      sub1_r     <= sa ^ sb;
      ebig1_r    <= a_big ? ea_e : eb_e;
      mbig1_r    <= a_big ? ma : mb;
      msml1_r    <= a_big ? mb : ma;
      dist1_r    <= (d_raw > 11'd63) ? 6'd63 : d_raw[5:0];

      st2_r      <= st1_r;
      alt_sel2_r <= alt_sel1_r;
      alt2_r     <= alt1_r;
      sign2_r    <= sign1_r;
      sub2_r     <= sub1_r;
      ebig2_r    <= ebig1_r;
      big2_r     <= {mbig1_r, 3'b000};
      sml2_r     <= {wide_c[119:65], wide_c[64] | (wide_c[63:0] != '0)};

      st3_r      <= st2_r;
      alt_sel3_r <= alt_sel2_r;
      alt3_r     <= alt2_r;
      sign3_r    <= sign2_r;
      ebig3_r    <= ebig2_r;
      sum3_r     <= sub2_r ? ({1'b0, big2_r} - {1'b0, sml2_r})
                           : ({1'b0, big2_r} + {1'b0, sml2_r});

      st4_r      <= st3_r;
      alt_sel4_r <= alt_sel3_r;
      alt4_r     <= alt3_r;
      sign4_r    <= sign3_r;
      zero4_r    <= (sum3_r == '0);
      if (sum3_r[56]) begin
        m4_r  <= {sum3_r[56:2], sum3_r[1] | sum3_r[0]};
        e4_r  <= {1'b0, ebig3_r} + 12'd1;
        sh4_r <= '0;
      end else begin
        m4_r  <= sum3_r[55:0];
        e4_r  <= {1'b0, ebig3_r};
        sh4_r <= ({5'd0, lz_c} > lim_c) ? lim_c[5:0] : lz_c;
      end

      st5_r      <= st4_r;
      alt_sel5_r <= alt_sel4_r;
      alt5_r     <= alt4_r;
      sign5_r    <= sign4_r;
      zero5_r    <= zero4_r;
      m5_r       <= m4_r << sh4_r;
      e5_r       <= e4_r - {6'd0, sh4_r};

      st6_r      <= st5_r;
      alt_sel6_r <= alt_sel5_r;
      alt6_r     <= alt5_r;
      zero6_r    <= zero5_r;
      d6_r       <= d_c;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 4'd9) else $error("byte count out of range");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_v_r[NUM_STAGES-1] |-> !in_stall) else $error("stall with empty tail");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_byte && !pipe_v_r[NUM_STAGES-1]) |=> !out_valid)
    else $error("bytes after last byte");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (cnt_r == $past(cnt_r)))
    else $error("count moved while stalled");

endmodule
